// ===== rtl/core/epr_pkg.sv =====
// shared types, constants, sine table and fixed-point helpers for the euler point rotation core
package epr_pkg;

    localparam int POS_W    = 32;
    localparam int ANG_W    = 16;
    localparam int TBL_LOG2 = 10;
    localparam int QTR_LOG2 = TBL_LOG2 - 2;
    localparam int QTR_N    = 1 << QTR_LOG2;
    localparam int TRIG_W   = 16;
    localparam int FRAC_W   = 15;
    localparam int COEF_W   = TRIG_W + 2;
    localparam int PROD_W   = POS_W + COEF_W;
    localparam int TERM_W   = PROD_W - FRAC_W;
    localparam int SUM_W    = TERM_W + 2;

    // angle step of one quarter-table entry in radians
    localparam real QSTEP   = 3.14159265358979323846 / (2.0 * real'(QTR_N));

    typedef logic signed [TRIG_W-1:0] trig_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [POS_W-1:0]  pos_t;
    typedef logic signed [TERM_W-1:0] term_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic [ANG_W-1:0]         angle_t;
    typedef logic [TBL_LOG2-1:0]      tidx_t;
    typedef trig_t                    qtab_t [QTR_N+1];

    typedef struct packed {
        trig_t s;
        trig_t c;
    } sincos_t;

    // quarter-wave table, entry k = round(32767*sin(pi/2*k/QTR_N))
    function automatic qtab_t make_qtab();
        qtab_t t;
        real   a;
        for (int k = 0; k <= QTR_N; k++) begin
            a = 32767.0 * $sin(QSTEP * real'(k));
            t[k] = TRIG_W'($rtoi(a + 0.5));
        end
        return t;
    endfunction

    localparam qtab_t QTAB = make_qtab();

    // full-circle lookup folded onto the quarter table
    function automatic trig_t sine_lookup(tidx_t idx);
        logic [1:0]        quad;
        logic [QTR_LOG2:0] k;
        trig_t             v;
        quad = idx[TBL_LOG2-1 -: 2];
        k    = {1'b0, idx[QTR_LOG2-1:0]};
        if (quad[0]) begin
            k = (QTR_LOG2+1)'(QTR_N) - k;
        end
        v = QTAB[k];
        return quad[1] ? -v : v;
    endfunction

    // q3.15 product with floor
    function automatic coef_t coef_mul(coef_t a, coef_t b);
        logic signed [2*COEF_W-1:0] p;
        p = a * b;
        return COEF_W'(p >>> FRAC_W);
    endfunction

    // position times coefficient with floor
    function automatic term_t pos_mul(pos_t a, coef_t b);
        logic signed [PROD_W-1:0] p;
        p = PROD_W'(a) * PROD_W'(b);
        return TERM_W'(p >>> FRAC_W);
    endfunction

    function automatic pos_t saturate(sum_t v);
        sum_t maxv;
        sum_t minv;
        maxv = SUM_W'({1'b0, {(POS_W-1){1'b1}}});
        minv = -maxv - SUM_W'(1);
        if (v > maxv) return {1'b0, {(POS_W-1){1'b1}}};
        if (v < minv) return {1'b1, {(POS_W-1){1'b0}}};
        return POS_W'(v);
    endfunction

endpackage

// ===== rtl/core/epr_sincos.sv =====
// registered sine and cosine lookup of one angle
module epr_sincos import epr_pkg::*; (
    input  logic    aclk,
    input  logic    en,
    input  angle_t  angle,
    output sincos_t sc_reg
);

    tidx_t   idx;
    tidx_t   cidx;
    sincos_t sc_next;

    always_comb begin
        idx       = angle[ANG_W-1 -: TBL_LOG2];
        cidx      = idx + TBL_LOG2'(QTR_N);
        sc_next.s = sine_lookup(idx);
        sc_next.c = sine_lookup(cidx);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sc_reg <= sc_next;
        end
    end

endmodule

// ===== rtl/core/euler_point_rotation_core.sv =====
// euler point rotation core: five-stage pipelined zyx rotation of one point per beat
//
//  channel | ports                               | dir | handshake
//  input   | s_pos_x/y/z, s_angle_yaw/pitch/roll | in  | s_valid / s_ready
//  result  | m_out_x/y/z                         | out | m_valid / m_ready
//
// one beat per cycle unless the result stalls; stages are table, trig products,
// coefficients, coordinate products, sum and saturate; multipliers set the pace
// synchronous active-low reset clears the stage valid bits only
// a stalled result holds every stage; s_ready is low only while the last stage
// is full and m_ready is low
module euler_point_rotation_core import epr_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  pos_t   s_pos_x,
    input  pos_t   s_pos_y,
    input  pos_t   s_pos_z,
    input  angle_t s_angle_yaw,
    input  angle_t s_angle_pitch,
    input  angle_t s_angle_roll,
    output logic   m_valid,
    input  logic   m_ready,
    output pos_t   m_out_x,
    output pos_t   m_out_y,
    output pos_t   m_out_z
);

    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    sincos_t yaw_reg, pitch_reg, roll_reg;
    pos_t    px1_reg, py1_reg, pz1_reg;
    pos_t    px2_reg, py2_reg, pz2_reg;
    pos_t    px3_reg, py3_reg, pz3_reg;

    // stage 2
    coef_t srsp_reg, crsp_reg, m00_reg, m01_reg, m12_reg, m22_reg;
    coef_t crsy_reg, crcy_reg, srsy_reg, srcy_reg, cy2_reg, sy2_reg, sp2_reg;
    // stage 3
    coef_t c00_reg, c01_reg, c02_reg, c10_reg, c11_reg, c12_reg;
    coef_t c20_reg, c21_reg, c22_reg;
    // stage 4
    term_t t00_reg, t01_reg, t02_reg, t10_reg, t11_reg, t12_reg;
    term_t t20_reg, t21_reg, t22_reg;
    // stage 5
    pos_t  ox_reg, oy_reg, oz_reg;

    sum_t  sx_next, sy_next, sz_next;

    assign en      = !v5_reg || m_ready;
    assign s_ready = en;
    assign m_valid = v5_reg;
    assign m_out_x = ox_reg;
    assign m_out_y = oy_reg;
    assign m_out_z = oz_reg;

    epr_sincos u_yaw (.aclk(aclk), .en(en), .angle(s_angle_yaw),   .sc_reg(yaw_reg));
    epr_sincos u_pit (.aclk(aclk), .en(en), .angle(s_angle_pitch), .sc_reg(pitch_reg));
    epr_sincos u_rol (.aclk(aclk), .en(en), .angle(s_angle_roll),  .sc_reg(roll_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_comb begin
        sx_next = SUM_W'(t00_reg) + SUM_W'(t01_reg) - SUM_W'(t02_reg);
        sy_next = SUM_W'(t10_reg) + SUM_W'(t11_reg) + SUM_W'(t12_reg);
        sz_next = SUM_W'(t20_reg) + SUM_W'(t21_reg) + SUM_W'(t22_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px1_reg <= s_pos_x;
            py1_reg <= s_pos_y;
            pz1_reg <= s_pos_z;

            // trig products
            srsp_reg <= coef_mul(COEF_W'(roll_reg.s), COEF_W'(pitch_reg.s));
            crsp_reg <= coef_mul(COEF_W'(roll_reg.c), COEF_W'(pitch_reg.s));
            m00_reg  <= coef_mul(COEF_W'(pitch_reg.c), COEF_W'(yaw_reg.c));
            m01_reg  <= coef_mul(COEF_W'(pitch_reg.c), COEF_W'(yaw_reg.s));
            m12_reg  <= coef_mul(COEF_W'(roll_reg.s), COEF_W'(pitch_reg.c));
            m22_reg  <= coef_mul(COEF_W'(roll_reg.c), COEF_W'(pitch_reg.c));
            crsy_reg <= coef_mul(COEF_W'(roll_reg.c), COEF_W'(yaw_reg.s));
            crcy_reg <= coef_mul(COEF_W'(roll_reg.c), COEF_W'(yaw_reg.c));
            srsy_reg <= coef_mul(COEF_W'(roll_reg.s), COEF_W'(yaw_reg.s));
            srcy_reg <= coef_mul(COEF_W'(roll_reg.s), COEF_W'(yaw_reg.c));
            cy2_reg  <= COEF_W'(yaw_reg.c);
            sy2_reg  <= COEF_W'(yaw_reg.s);
            sp2_reg  <= COEF_W'(pitch_reg.s);
            px2_reg  <= px1_reg;
            py2_reg  <= py1_reg;
            pz2_reg  <= pz1_reg;

            // matrix coefficients
            c00_reg <= m00_reg;
            c01_reg <= m01_reg;
            c02_reg <= sp2_reg;
            c10_reg <= coef_mul(srsp_reg, cy2_reg) - crsy_reg;
            c11_reg <= coef_mul(srsp_reg, sy2_reg) + crcy_reg;
            c12_reg <= m12_reg;
            c20_reg <= coef_mul(crsp_reg, cy2_reg) + srsy_reg;
            c21_reg <= coef_mul(crsp_reg, sy2_reg) - srcy_reg;
            c22_reg <= m22_reg;
            px3_reg <= px2_reg;
            py3_reg <= py2_reg;
            pz3_reg <= pz2_reg;

            // coordinate products
            t00_reg <= pos_mul(px3_reg, c00_reg);
            t01_reg <= pos_mul(py3_reg, c01_reg);
            t02_reg <= pos_mul(pz3_reg, c02_reg);
            t10_reg <= pos_mul(px3_reg, c10_reg);
            t11_reg <= pos_mul(py3_reg, c11_reg);
            t12_reg <= pos_mul(pz3_reg, c12_reg);
            t20_reg <= pos_mul(px3_reg, c20_reg);
            t21_reg <= pos_mul(py3_reg, c21_reg);
            t22_reg <= pos_mul(pz3_reg, c22_reg);

            // sum and saturate
            ox_reg <= saturate(sx_next);
            oy_reg <= saturate(sy_next);
            oz_reg <= saturate(sz_next);
        end
    end

endmodule
